@@ design/eqd_pkg.sv @@
package eqd_pkg;

  // Filter coefficients, signed Q4.20. Feedback terms are stored negated so the
  // accumulator only adds.
  localparam logic signed [23:0] CoefB0 = 24'sd19556;
  localparam logic signed [23:0] CoefB2 = -24'sd39112;
  localparam logic signed [23:0] CoefB4 = 24'sd19556;

  localparam int unsigned MacSteps = 11;

  localparam logic signed [67:0] RoundHalf = 68'sd524288;
  localparam logic signed [67:0] YMax = 68'sd549755813887;
  localparam logic signed [67:0] YMin = -68'sd549755813888;

  localparam logic [9:0] DelayMax = 10'd1023;

  // configuration register indexes
  localparam logic [1:0] CfgLearnWindow = 2'd0;
  localparam logic [1:0] CfgRiseDelay = 2'd1;
  localparam logic [1:0] CfgRefractoryEnd = 2'd2;

  localparam logic [15:0] LearnWindowRst = 16'd250;
  localparam logic [7:0] RiseDelayRst = 8'd10;
  localparam logic [9:0] RefractoryEndRst = 10'd75;

  typedef struct packed {
    logic [15:0] learn_window;
    logic [7:0]  rise_delay;
    logic [9:0]  refractory_end;
  } cfg_t;

  function automatic logic signed [23:0] neg_fb_coef(input logic [1:0] k);
    logic signed [23:0] c;
    case (k)
      2'd0: c = 24'sd3562608;
      2'd1: c = -24'sd4709436;
      2'd2: c = 24'sd2871316;
      default: c = -24'sd684550;
    endcase
    return c;
  endfunction

endpackage

@@ design/eqd_front.sv @@
module eqd_front #(
  parameter int SMOOTH_LEN = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] in_sample_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output logic [15:0] push_feature_o
);
  import eqd_pkg::*;

  localparam int IW = (SMOOTH_LEN > 1) ? $clog2(SMOOTH_LEN) : 1;
  localparam int SW = 16 + $clog2(SMOOTH_LEN);
  localparam int LBW = $clog2(SMOOTH_LEN + 1);
  localparam logic [SW-1:0] RecipM = SW'((2 ** SW) / SMOOTH_LEN);
  localparam logic [LBW-1:0] LenC = LBW'(SMOOTH_LEN);
  localparam logic [31:0] SatLim = 32'(65536 * SMOOTH_LEN);
  localparam logic [IW-1:0] IdxLast = IW'(SMOOTH_LEN - 1);

  localparam logic [2:0] FIdle = 3'd0;
  localparam logic [2:0] FMac = 3'd1;
  localparam logic [2:0] FY = 3'd2;
  localparam logic [2:0] FSum = 3'd3;
  localparam logic [2:0] FDiv1 = 3'd4;
  localparam logic [2:0] FDiv2 = 3'd5;
  localparam logic [2:0] FDiv3 = 3'd6;
  localparam logic [2:0] FPush = 3'd7;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q;
  logic signed [15:0] xh_q [4];
  logic signed [39:0] yh_q [4];
  logic signed [15:0] x_q;
  logic signed [39:0] y_q, prev_q;
  logic signed [44:0] prod_q;
  logic [1:0] psh_q;
  logic pv_q;
  logic signed [67:0] acc_q;
  logic [39:0] win_mem [SMOOTH_LEN];
  logic [SMOOTH_LEN-1:0] wvalid_q;
  logic [IW-1:0] idx_q;
  logic [39:0] old_q;
  logic oldv_q;
  logic [47:0] sum_q;
  logic [31:0] s_q;
  logic [2*SW-1:0] div_p_q;
  logic [15:0] q0_q;
  logic [16+LBW-1:0] div_m_q;
  logic [15:0] feat_q;

  // multiplier operand select
  logic signed [20:0] mul_a;
  logic signed [23:0] mul_c;
  logic [1:0] mul_sh;
  logic [1:0] k;
  always_comb begin
    k = 2'(step_q - 4'd3);
    mul_a = '0;
    mul_c = '0;
    mul_sh = 2'd0;
    if (step_q == 4'd0) begin
      mul_a = 21'(x_q);
      mul_c = CoefB0;
      mul_sh = 2'd1;
    end else if (step_q == 4'd1) begin
      mul_a = 21'(xh_q[1]);
      mul_c = CoefB2;
      mul_sh = 2'd1;
    end else if (step_q == 4'd2) begin
      mul_a = 21'(xh_q[3]);
      mul_c = CoefB4;
      mul_sh = 2'd1;
    end else if (step_q < 4'd7) begin
      mul_a = $signed({1'b0, yh_q[k][19:0]});
      mul_c = neg_fb_coef(k);
      mul_sh = 2'd0;
    end else begin
      k = 2'(step_q - 4'd7);
      mul_a = 21'($signed(yh_q[k][39:20]));
      mul_c = neg_fb_coef(k);
      mul_sh = 2'd2;
    end
  end

  logic signed [67:0] prod_ext, acc_add;
  always_comb begin
    prod_ext = 68'(prod_q);
    case (psh_q)
      2'd1: acc_add = prod_ext <<< 16;
      2'd2: acc_add = prod_ext <<< 20;
      default: acc_add = prod_ext;
    endcase
  end

  logic signed [67:0] acc_r, y_w;
  logic signed [39:0] y_sat;
  always_comb begin
    acc_r = acc_q + RoundHalf;
    y_w = acc_r >>> 20;
    if (y_w > YMax) y_sat = 40'(YMax);
    else if (y_w < YMin) y_sat = 40'(YMin);
    else y_sat = 40'(y_w);
  end

  logic signed [40:0] diff;
  logic [39:0] dabs, old_v;
  logic [47:0] sum_n;
  always_comb begin
    diff = 41'(y_q) - 41'(prev_q);
    dabs = diff[40] ? 40'(-diff) : 40'(diff);
    old_v = oldv_q ? old_q : '0;
    sum_n = sum_q + 48'(dabs) - 48'(old_v);
  end

  logic [SW:0] rem;
  always_comb begin
    rem = {1'b0, s_q[SW-1:0]} - (SW + 1)'(div_m_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FIdle: if (in_valid_i) state_d = FMac;
      FMac: if (step_q == 4'(MacSteps)) state_d = FY;
      FY: state_d = FSum;
      FSum: state_d = FDiv1;
      FDiv1: state_d = FDiv2;
      FDiv2: state_d = FDiv3;
      FDiv3: state_d = FPush;
      FPush: if (push_ready_i) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      step_q <= '0;
      pv_q <= 1'b0;
      idx_q <= '0;
      wvalid_q <= '0;
      sum_q <= '0;
      prev_q <= '0;
      for (int i = 0; i < 4; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pv_q <= (state_q == FMac) && (step_q < 4'(MacSteps));
      if (state_q == FIdle) step_q <= '0;
      else if (state_q == FMac) step_q <= step_q + 4'd1;
      if (state_q == FY) begin
        xh_q[0] <= x_q;
        yh_q[0] <= y_sat;
        for (int i = 1; i < 4; i++) begin
          xh_q[i] <= xh_q[i-1];
          yh_q[i] <= yh_q[i-1];
        end
      end
      if (state_q == FSum) begin
        prev_q <= y_q;
        sum_q <= sum_n;
        wvalid_q[idx_q] <= 1'b1;
        idx_q <= (idx_q == IdxLast) ? '0 : idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FIdle && in_valid_i) begin
      x_q <= in_sample_i;
      acc_q <= '0;
      old_q <= win_mem[idx_q];
      oldv_q <= wvalid_q[idx_q];
    end else if (pv_q) begin
      acc_q <= acc_q + acc_add;
    end
    prod_q <= 45'(mul_a) * 45'(mul_c);
    psh_q <= mul_sh;
    if (state_q == FY) y_q <= y_sat;
    if (state_q == FSum) win_mem[idx_q] <= dabs;
    if (state_q == FDiv1 - 3'd1) s_q <= sum_n[47:16];
    if (state_q == FDiv1) div_p_q <= s_q[SW-1:0] * RecipM;
    if (state_q == FDiv2) begin
      q0_q <= div_p_q[SW +: 16];
      div_m_q <= div_p_q[SW +: 16] * LenC;
    end
    if (state_q == FDiv3) begin
      if (s_q >= SatLim) feat_q <= 16'hFFFF;
      else if (rem >= (SW + 1)'(LenC)) feat_q <= q0_q + 16'd1;
      else feat_q <= q0_q;
    end
  end

  assign in_ready_o = (state_q == FIdle);
  assign push_valid_o = (state_q == FPush);
  assign push_feature_o = feat_q;

endmodule

@@ design/eqd_fifo.sv @@
module eqd_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_ready_o,
  input  logic [15:0] wr_data_i,
  output logic        rd_valid_o,
  input  logic        rd_ready_i,
  output logic [15:0] rd_data_o
);
  logic [15:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

@@ design/eqd_back.sv @@
module eqd_back #(
  parameter int LEARN_PEAKS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  eqd_pkg::cfg_t cfg_i,
  input  logic          feat_valid_i,
  output logic          feat_ready_o,
  input  logic [15:0]   feat_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_qrs_o,
  output logic [15:0]   out_feature_o,
  output logic          out_learning_o
);
  import eqd_pkg::*;

  localparam int PIW = (LEARN_PEAKS > 1) ? $clog2(LEARN_PEAKS) : 1;
  localparam int CW = $clog2(LEARN_PEAKS + 1);
  localparam logic [CW-1:0] PeakCnt = CW'(LEARN_PEAKS);
  localparam logic [CW-1:0] MedIdx = CW'(LEARN_PEAKS / 2);
  localparam logic [PIW-1:0] PeakLast = PIW'(LEARN_PEAKS - 1);

  localparam logic [1:0] PhWait = 2'd0;
  localparam logic [1:0] PhRise = 2'd1;
  localparam logic [1:0] PhFall = 2'd2;
  localparam logic [1:0] PhRefr = 2'd3;

  logic [15:0] peak_q [LEARN_PEAKS];
  logic [CW-1:0] pl_q, pl_d;
  logic [15:0] cnt_q, cnt_d, wmax_q, wmax_d, thr_q, thr_d;
  logic [1:0] ph_q, ph_d;
  logic [9:0] dc_q, dc_d;
  logic sort_q, sort_d;
  logic [PIW-1:0] sidx_q, sidx_d;
  logic ovalid_q;
  logic oqrs_q, olearn_q;
  logic [15:0] ofeat_q;
  logic pop, learning, qrs, peak_wr;
  logic [15:0] cnt_inc, wmax_n;
  logic [9:0] dc_inc;

  assign feat_ready_o = !sort_q && (!ovalid_q || out_ready_i);
  assign pop = feat_valid_i && feat_ready_o;
  assign learning = (pl_q < PeakCnt);
  assign cnt_inc = cnt_q + 16'd1;
  assign wmax_n = (feat_i > wmax_q) ? feat_i : wmax_q;
  assign dc_inc = (dc_q < DelayMax) ? dc_q + 10'd1 : dc_q;

  // median search: one candidate per cycle, compared against all peaks
  logic [LEARN_PEAKS-1:0] gt_v, ge_v;
  logic [CW-1:0] gt_n, ge_n;
  logic [15:0] cand;
  always_comb begin
    cand = peak_q[sidx_q];
    for (int j = 0; j < LEARN_PEAKS; j++) begin
      gt_v[j] = peak_q[j] > cand;
      ge_v[j] = peak_q[j] >= cand;
    end
    gt_n = CW'($countones(gt_v));
    ge_n = CW'($countones(ge_v));
  end

  always_comb begin
    pl_d = pl_q;
    cnt_d = cnt_q;
    wmax_d = wmax_q;
    thr_d = thr_q;
    ph_d = ph_q;
    dc_d = dc_q;
    sort_d = sort_q;
    sidx_d = sidx_q;
    qrs = 1'b0;
    peak_wr = 1'b0;
    if (sort_q) begin
      if (gt_n <= MedIdx && ge_n > MedIdx) thr_d = cand >> 1;
      if (sidx_q == PeakLast) sort_d = 1'b0;
      else sidx_d = sidx_q + PIW'(1);
    end else if (pop) begin
      if (learning) begin
        wmax_d = wmax_n;
        cnt_d = cnt_inc;
        if (cnt_inc >= cfg_i.learn_window) begin
          cnt_d = '0;
          wmax_d = '0;
          ph_d = PhWait;
          peak_wr = 1'b1;
          pl_d = pl_q + CW'(1);
          if (pl_q + CW'(1) == PeakCnt) begin
            sort_d = 1'b1;
            sidx_d = '0;
          end
        end
      end else begin
        unique case (ph_q)
          PhWait: if (feat_i > thr_q) ph_d = PhRise;
          PhRise: begin
            dc_d = dc_inc;
            if (dc_inc >= 10'(cfg_i.rise_delay)) ph_d = PhFall;
          end
          PhFall: if (feat_i < thr_q) begin
            qrs = 1'b1;
            ph_d = PhRefr;
          end
          PhRefr: begin
            dc_d = dc_inc;
            if (dc_inc >= cfg_i.refractory_end) begin
              ph_d = PhWait;
              dc_d = '0;
            end
          end
          default: ph_d = PhWait;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q <= '0;
      cnt_q <= '0;
      wmax_q <= '0;
      thr_q <= '0;
      ph_q <= PhWait;
      dc_q <= '0;
      sort_q <= 1'b0;
      sidx_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pl_q <= pl_d;
      cnt_q <= cnt_d;
      wmax_q <= wmax_d;
      thr_q <= thr_d;
      ph_q <= ph_d;
      dc_q <= dc_d;
      sort_q <= sort_d;
      sidx_q <= sidx_d;
      if (pop) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (peak_wr) peak_q[pl_q[PIW-1:0]] <= wmax_n;
    if (pop) begin
      oqrs_q <= qrs;
      ofeat_q <= feat_i;
      olearn_q <= learning;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_qrs_o = oqrs_q;
  assign out_feature_o = ofeat_q;
  assign out_learning_o = olearn_q;

endmodule

@@ design/ecg_qrs_detector_core.sv @@
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/tready         tdata[15:0] sample
// m_axis    out  m_axis_tvalid/tready         tdata[0] is_qrs, [16:1] feature; tuser learning
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// In the front end a sample makes 11 passes through the shared filter multiplier,
// then output rounding, difference/moving sum and a divide in FDiv1, FDiv2, FDiv3.
// Back end takes one item per cycle while the output is not stalled; after the last
// learning window it pauses for a median search. A 2-entry queue parts front and back.
// Reset clears all history and returns the config registers to their defaults.
module ecg_qrs_detector_core #(
  parameter int SMOOTH_LEN = 25,
  parameter int LEARN_PEAKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] is_qrs, [16:1] feature, zero pad
  output logic        m_axis_tuser,   // [0] learning
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import eqd_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, q_valid, q_ready;
  logic [15:0] push_feat, q_feat, o_feat;
  logic o_qrs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_window <= LearnWindowRst;
      cfg_q.rise_delay <= RiseDelayRst;
      cfg_q.refractory_end <= RefractoryEndRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLearnWindow: cfg_q.learn_window <= cfg_data_i;
        CfgRiseDelay: cfg_q.rise_delay <= cfg_data_i[7:0];
        CfgRefractoryEnd: cfg_q.refractory_end <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  eqd_front #(.SMOOTH_LEN(SMOOTH_LEN)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_sample_i(s_axis_tdata),
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_feature_o(push_feat)
  );

  eqd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(push_valid), .wr_ready_o(push_ready), .wr_data_i(push_feat),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_feat)
  );

  eqd_back #(.LEARN_PEAKS(LEARN_PEAKS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .feat_valid_i(q_valid), .feat_ready_o(q_ready), .feat_i(q_feat),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_qrs_o(o_qrs), .out_feature_o(o_feat), .out_learning_o(m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, o_feat, o_qrs};

endmodule

@@ design/eqd_checker.sv @@
module eqd_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no detection is flagged while learning
  a_qrs_not_learning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tuser)
    else $error("qrs flagged during learning");

  // front works on one sample at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample accepted while busy");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
    else $error("nonzero pad bits");
endmodule

bind ecg_qrs_detector_core eqd_sva u_eqd_sva (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
